### src/rvf_pkg.sv
// Package for the rail voltmeter filter: payload structs, message codes and
// fixed datapath constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rvf_pkg;

    // Default parameter values for the top level.
    localparam int SamplesPerFrameDef = 16;
    localparam int BootFramesDef      = 100;

    // Fixed datapath widths and constants.
    localparam int SumW       = 14;
    localparam int AvgW       = 16;
    localparam int ReadW      = 11;
    localparam int CfgW       = 8;
    localparam logic [ReadW-1:0] FullScale = 11'd1534;
    localparam logic [CfgW-1:0]  DebounceReloadRst = 8'd100;
    localparam logic [CfgW-1:0]  MessageFramesRst  = 8'd60;

    // Configuration register indexes.
    typedef enum logic {
        CFG_DEBOUNCE_RELOAD = 1'b0,
        CFG_MESSAGE_FRAMES  = 1'b1
    } t_cfg_idx;

    // Display message codes.
    typedef enum logic [1:0] {
        MSG_READING = 2'd0,
        MSG_BOOT    = 2'd1,
        MSG_POS     = 2'd2,
        MSG_NEG     = 2'd3
    } t_msg;

    // One poll item.
    typedef struct packed {
        logic       button_level;
        logic       sample_valid;
        logic [9:0] sample;
    } t_in_item;

    // One frame result item.
    typedef struct packed {
        logic [ReadW-1:0] reading;
        logic [1:0]       message;
        logic             point_on;
        logic             rail_negative;
    } t_out_item;

endpackage

`default_nettype wire

### src/rail_voltmeter_filter.sv
// Top level of the rail voltmeter filter: input register, button debounce,
// sample accumulation, frame message control and result register.
// Depends on rvf_pkg and rvf_ewma.
//
//   Channel | Direction | Handshake                   | Payload
//   --------+-----------+-----------------------------+---------------------------
//   in      | input     | i_in_valid / o_in_ready     | i_in  (t_in_item)
//   out     | output    | o_out_valid / i_out_ready   | o_out (t_out_item)
//   cfg     | input     | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// One item enters per cycle unless the output register holds a result that is not
// taken. An item is held in the input register, then updates all state in one pass;
// a frame-closing item loads its result into the output register.
// The input register advances whenever the output register is empty or is being
// taken. Reset is synchronous and active low; configuration is always ready.
`timescale 1ns / 1ps
`default_nettype none

module rail_voltmeter_filter
    import rvf_pkg::*;
#(
    parameter int SAMPLES_PER_FRAME = SamplesPerFrameDef,
    parameter int BOOT_FRAMES       = BootFramesDef
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic      i_cfg_index,
    input  wire logic [CfgW-1:0] i_cfg_data
);

    localparam int CntW = $clog2(SAMPLES_PER_FRAME);
    localparam logic [CntW-1:0] CntLast = CntW'(SAMPLES_PER_FRAME - 1);

    // Registers.
    logic [CfgW-1:0]  r_debounce_reload, r_message_frames;
    t_in_item         r_in;
    logic             r_in_vld;
    t_out_item        r_out;
    logic             r_out_vld;
    logic [CntW-1:0]  r_count;
    logic [SumW-1:0]  r_sum;
    logic [AvgW-1:0]  r_avg;
    logic [CfgW-1:0]  r_timer;
    t_msg             r_kind;
    logic             r_point;
    logic             r_stable;
    logic [CfgW-1:0]  r_db_cnt;
    logic             r_pending;
    logic             r_active;

    // Next values.
    logic             process;
    logic             frame_done;
    logic [CfgW-1:0]  db_dec;
    logic             n_stable;
    logic [CfgW-1:0]  n_db_cnt;
    logic             n_pending;
    logic [SumW-1:0]  sum_add;
    logic [AvgW-1:0]  n_avg;
    logic [ReadW-1:0] value;
    logic [CfgW-1:0]  n_timer;
    t_msg             n_kind;
    logic             n_point;
    logic             n_active;

    assign process     = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || process;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_reload <= DebounceReloadRst;
            r_message_frames  <= MessageFramesRst;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DEBOUNCE_RELOAD: r_debounce_reload <= i_cfg_data;
                CFG_MESSAGE_FRAMES:  r_message_frames  <= i_cfg_data;
                default:             r_debounce_reload <= r_debounce_reload;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // Button debounce: a changed level counts down, the stable level reloads.
    assign db_dec = r_db_cnt - CfgW'(1);
    always_comb begin
        n_stable  = r_stable;
        n_pending = r_pending;
        n_db_cnt  = r_debounce_reload;
        if (r_in.button_level != r_stable) begin
            n_db_cnt = db_dec;
            if (db_dec == '0) begin
                n_stable = ~r_stable;
                n_db_cnt = r_debounce_reload;
                if (r_stable) begin
                    n_pending = ~r_pending;
                end
            end
        end
    end

    // Sample accumulation; the last sample of a frame closes it.
    assign sum_add    = r_sum + SumW'(r_in.sample);
    assign frame_done = r_in.sample_valid && (r_count == CntLast);

    rvf_ewma u_ewma (
        .i_frame_sum     (sum_add[SumW-1:2]),
        .i_avg           (r_avg),
        .i_rail_negative (r_active),
        .o_avg           (n_avg),
        .o_value         (value)
    );

    // Frame message update and rail switch.
    always_comb begin
        n_timer  = r_timer;
        n_kind   = r_kind;
        n_point  = r_point;
        n_active = r_active;
        if (r_timer == '0) begin
            n_kind  = MSG_READING;
            n_point = 1'b1;
        end else begin
            n_timer = r_timer - CfgW'(1);
        end
        if (n_pending != r_active) begin
            n_active = n_pending;
            n_timer  = r_message_frames;
            n_point  = 1'b0;
            n_kind   = n_pending ? MSG_NEG : MSG_POS;
        end
    end

    // State update for each processed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_sum     <= '0;
            r_avg     <= '0;
            r_timer   <= CfgW'(BOOT_FRAMES);
            r_kind    <= MSG_BOOT;
            r_point   <= 1'b0;
            r_stable  <= 1'b1;
            r_db_cnt  <= '0;
            r_pending <= 1'b0;
            r_active  <= 1'b0;
        end else if (process) begin
            r_stable  <= n_stable;
            r_db_cnt  <= n_db_cnt;
            r_pending <= n_pending;
            if (frame_done) begin
                r_count  <= '0;
                r_sum    <= '0;
                r_avg    <= n_avg;
                r_timer  <= n_timer;
                r_kind   <= n_kind;
                r_point  <= n_point;
                r_active <= n_active;
            end else if (r_in.sample_valid) begin
                r_count <= r_count + CntW'(1);
                r_sum   <= sum_add;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (process && frame_done) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && frame_done) begin
            r_out.reading       <= value;
            r_out.message       <= n_kind;
            r_out.point_on      <= n_point;
            r_out.rail_negative <= n_active;
        end
    end

endmodule

`default_nettype wire

### src/rvf_ewma.sv
// Frame filter: exponentially weighted average update and display scaling.
// Purely combinational; depends on rvf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rvf_ewma
    import rvf_pkg::*;
(
    input  wire logic [SumW-3:0]  i_frame_sum,
    input  wire logic [AvgW-1:0]  i_avg,
    input  wire logic             i_rail_negative,
    output logic      [AvgW-1:0]  o_avg,
    output logic      [ReadW-1:0] o_value
);

    logic [AvgW-4:0] decay;
    logic [AvgW:0]   avg_sum;
    logic [AvgW-4:0] avg_div;
    logic [AvgW-1:0] scaled;
    logic [ReadW-1:0] raw;

    // Decay term: (avg - 4) / 8 truncating toward zero, so zero below four.
    always_comb begin
        if (i_avg < AvgW'(4)) begin
            decay = '0;
        end else begin
            decay = (AvgW-3)'((i_avg - AvgW'(4)) >> 3);
        end
    end

    // New average wraps at sixteen bits.
    assign avg_sum = (AvgW+1)'(i_avg) + (AvgW+1)'(i_frame_sum) - (AvgW+1)'(decay);
    assign o_avg   = avg_sum[AvgW-1:0];

    // Scale by 12/32 of the average divided by eight; the product wraps at 16 bits.
    assign avg_div = o_avg[AvgW-1:3];
    assign scaled  = AvgW'({avg_div, 3'b000}) + AvgW'({avg_div, 2'b00});
    assign raw     = scaled[AvgW-1:5];

    // Invert for the negative rail, or clamp to full scale for the positive one.
    always_comb begin
        if (i_rail_negative) begin
            o_value = (raw >= FullScale) ? '0 : FullScale - raw;
        end else begin
            o_value = (raw > FullScale) ? FullScale : raw;
        end
    end

endmodule

`default_nettype wire
